// File: rtl/torq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_pkg
// Shared types, sizes and codes for the timestamp-ordered request queue.
// ----------------------------------------------------------------------------
package torq_pkg;

    localparam int DEPTH      = 16;
    localparam int STAMP_BITS = 16;
    localparam int PROC_BITS  = 8;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [PROC_BITS-1:0]  proc_id;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   update;   // item accepted and it changes the queue if it applies
        logic   remove;   // 1 remove, 0 insert
        entry_t req;      // new entry / process id to remove
    } cell_ctrl_t;

    // true when key a is strictly greater than key b (stamp first, then id)
    function automatic logic key_after(entry_t a, entry_t b);
        if (a.stamp != b.stamp) begin
            return a.stamp > b.stamp;
        end
        return a.proc_id > b.proc_id;
    endfunction

endpackage

// File: rtl/torq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_cell
// One slot of the sorted chain: holds an entry, decides locally whether to
// keep it, take the new entry, or take the left or right neighbor's entry.
// ----------------------------------------------------------------------------
module torq_cell (
    input  logic                aclk,
    input  torq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,    // slot index below the fill count
    input  torq_pkg::entry_t    left_entry,  // neighbor toward the head
    input  torq_pkg::entry_t    right_entry, // neighbor toward the tail
    input  logic                shift_in,    // left neighbor shifts on insert
    input  logic                hit_in,      // a match already seen nearer the head
    output logic                shift_out,
    output logic                hit_out,
    output torq_pkg::entry_t    entry,
    output torq_pkg::entry_t    entry_next
);
    import torq_pkg::*;

    entry_t entry_reg;
    logic   match;

    // insert: this slot moves when its key is after the new one or it is free
    assign shift_out = !occupied || key_after(entry_reg, ctrl.req);
    // remove: first matching slot and all slots behind it pull from the right
    assign match   = occupied && (entry_reg.proc_id == ctrl.req.proc_id);
    assign hit_out = hit_in || match;

    // next entry
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.update) begin
            if (ctrl.remove) begin
                if (hit_out) begin
                    entry_next = right_entry;
                end
            end else if (shift_out) begin
                entry_next = shift_in ? left_entry : ctrl.req;
            end
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/timestamp_ordered_request_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_ordered_request_queue
// Bounded queue of requests kept sorted by (timestamp, process id).
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_): each transfer is one request. s_tuser[0] selects
//   insert (0) or remove by process id (1); s_tdata carries the process id
//   and the timestamp (ignored on remove).
//   Result stream (m_): exactly one transfer per request, carrying the
//   status and head valid flag in m_tuser and the head entry and fill count
//   in m_tdata.
//   The result is registered and offered in the cycle after the request transfer.
//   Throughput: one request per cycle; every slot cell compares against the
//   request in parallel and shifts left or right in the same cycle, with the
//   first-match flag rippling along the chain of DEPTH cells.
//   A result waiting in the output register does not block the input as
//   long as m_tready takes it in the same cycle; with the receiver stalled,
//   s_tready drops and the held result stays unchanged.
//   Reset empties the queue (fill count zero) and drops any pending result;
//   slot contents are not cleared, they are never read before written.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] proc_id, [23:8] stamp
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] head_proc, [23:8] head_stamp, [28:24] fill
    output logic [2:0]  m_tuser    // [1:0] status, [2] head_valid
);
    import torq_pkg::*;

    logic             accept;
    logic             full;
    cell_ctrl_t       ctrl;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [1:0]       status;

    logic   occ   [DEPTH];
    logic   shift [DEPTH];
    logic   hit   [DEPTH];
    entry_t ent   [DEPTH];
    entry_t ent_n [DEPTH];

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [2:0]  out_user_reg;
    entry_t      head;
    logic        head_valid;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (held_reg == CNT_W'(DEPTH));

    // broadcast to the cells
    always_comb begin
        ctrl.remove      = s_tuser[0];
        ctrl.req.proc_id = s_tdata[7:0];
        ctrl.req.stamp   = s_tdata[23:8];
        ctrl.update      = accept && (ctrl.remove || !full);
    end

    // slot chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign occ[i] = (CNT_W'(i) < held_reg);
        torq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .left_entry  ((i == 0) ? ent[0] : ent[(i == 0) ? 0 : i - 1]),
            .right_entry (ent[(i == DEPTH - 1) ? i : i + 1]),
            .shift_in    ((i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i - 1]),
            .hit_in      ((i == 0) ? 1'b0 : hit[(i == 0) ? 0 : i - 1]),
            .shift_out   (shift[i]),
            .hit_out     (hit[i]),
            .entry       (ent[i]),
            .entry_next  (ent_n[i])
        );
    end

    // status and next fill count
    always_comb begin
        held_next = held_reg;
        status    = ST_DONE;
        if (ctrl.remove) begin
            if (hit[DEPTH-1]) begin
                held_next = held_reg - CNT_W'(1);
            end else begin
                status = ST_NOT_FOUND;
            end
        end else if (full) begin
            status = ST_FULL;
        end else begin
            held_next = held_reg + CNT_W'(1);
        end
    end

    assign head_valid = (held_next != '0);
    assign head       = head_valid ? ent_n[0] : '0;

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (accept) begin
            held_reg <= held_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {3'b000, 5'(held_next), head.stamp, head.proc_id};
            out_user_reg <= {head_valid, status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_head_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2] == (m_tdata[28:24] != 5'd0)))
        else $error("head valid flag disagrees with fill count");

    a_full_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == ST_FULL) |-> (m_tdata[28:24] == 5'(DEPTH)))
        else $error("insert refused while not full");

    a_sorted_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg >= CNT_W'(2)) |-> !key_after(ent[0], ent[1]))
        else $error("head pair out of key order");

endmodule

// File: dv/tb_timestamp_ordered_request_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamp_ordered_request_queue
// Self-checking bench for the timestamp-ordered request queue. A short table
// of directed requests covers empty and full queues, key ties, duplicate ids
// and absent ids. Random insert/remove traffic then drives the queue between
// empty and full. Each result transfer is checked against a software copy of
// the sorted queue or a hand-written result. Both streams idle at random, and
// one long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module tb_timestamp_ordered_request_queue;
    import torq_pkg::*;

    localparam int RANDOM_ITEMS = 628;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int BACKLOG_LEN  = 80;

    // one result transfer, unpacked
    typedef struct packed {
        logic [1:0]            status;
        logic                  head_valid;
        logic [PROC_BITS-1:0]  head_proc;
        logic [STAMP_BITS-1:0] head_stamp;
        logic [CNT_W-1:0]      fill;
    } head_report_t;

    // directed request, with an optional hand-written result
    typedef struct packed {
        logic         kind;
        entry_t       req;
        logic         typed;
        head_report_t want;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // [7:0] proc_id, [23:8] stamp
    logic [0:0]  s_tuser  = '0;     // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] head_proc, [23:8] head_stamp, [28:24] fill
    logic [2:0]  m_tuser;           // [1:0] status, [2] head_valid

    // software copy of the sorted queue
    entry_t       sorted_slots [DEPTH];
    int           slot_count = 0;
    head_report_t head_reports [$];
    dir_row_t     directed_rows [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  hold_left      = 0;
    bit  quiet          = 1'b0;
    bit  backlog_req    = 1'b0;
    bit  backlog_done   = 1'b0;

    timestamp_ordered_request_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Apply one request to the software queue and report the new head.
    function automatic head_report_t apply_request(input logic kind, input entry_t e);
        head_report_t r;
        int pos;
        r = '0;
        r.status = ST_DONE;
        pos = 0;
        if (kind == REQ_INSERT) begin
            if (slot_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new entry lands after every key that is not larger
                while (pos < slot_count &&
                       {sorted_slots[pos].stamp, sorted_slots[pos].proc_id} <=
                       {e.stamp, e.proc_id}) begin
                    pos++;
                end
                for (int i = slot_count; i > pos; i--) begin
                    sorted_slots[i] = sorted_slots[i-1];
                end
                sorted_slots[pos] = e;
                slot_count++;
            end
        end else begin
            // first entry in key order with this id
            while (pos < slot_count && sorted_slots[pos].proc_id != e.proc_id) begin
                pos++;
            end
            if (pos >= slot_count) begin
                r.status = ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < slot_count; i++) begin
                    sorted_slots[i] = sorted_slots[i+1];
                end
                slot_count--;
            end
        end
        if (slot_count > 0) begin
            r.head_valid = 1'b1;
            r.head_proc  = sorted_slots[0].proc_id;
            r.head_stamp = sorted_slots[0].stamp;
        end
        r.fill = CNT_W'(slot_count);
        return r;
    endfunction

    // Offer one request, wait for its transfer, then log the expected result.
    task automatic offer_request(input logic kind, input entry_t e, input logic typed,
                                 input head_report_t want);
        head_report_t predicted;
        while (!quiet && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {e.stamp, e.proc_id};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(kind, e);
        head_reports.push_back(typed ? want : predicted);
    endtask

    task automatic add_row(input logic kind, input logic [7:0] pid, input logic [15:0] stamp,
                           input logic typed, input logic [1:0] status, input logic hv,
                           input logic [7:0] hp, input logic [15:0] hs, input logic [4:0] fill);
        dir_row_t row;
        row.kind  = kind;
        row.req   = '{proc_id: pid, stamp: stamp};
        row.typed = typed;
        row.want  = '{status: status, head_valid: hv, head_proc: hp, head_stamp: hs,
                      fill: fill};
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, quiet stretch.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (backlog_req && !backlog_done) begin
            hold_left    <= BACKLOG_LEN;
            backlog_done <= 1'b1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 10);
        end
    end

    // Result checker: every transfer against the oldest expectation.
    always @(posedge aclk) begin
        head_report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = m_tuser[1:0];
            got.head_valid = m_tuser[2];
            got.head_proc  = m_tdata[7:0];
            got.head_stamp = m_tdata[23:8];
            got.fill       = m_tdata[28:24];
            if (head_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0h", $time, got);
                mismatch_count++;
            end else begin
                want = head_reports.pop_front();
                check_field("status", want.status, got.status);
                check_field("head_valid", want.head_valid, got.head_valid);
                check_field("head_proc", want.head_proc, got.head_proc);
                check_field("head_stamp", want.head_stamp, got.head_stamp);
                check_field("fill", want.fill, got.fill);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        entry_t e;
        logic   kind;
        int     fill_bias;

        // empty queue, extremes, ties, duplicate ids, absent id
        add_row(REQ_REMOVE, 8'd0,   16'h0000, 1'b1, ST_NOT_FOUND, 1'b0, 8'd0, 16'h0000, 5'd0);
        add_row(REQ_INSERT, 8'd255, 16'hFFFF, 1'b1, ST_DONE, 1'b1, 8'd255, 16'hFFFF, 5'd1);
        add_row(REQ_INSERT, 8'd0,   16'h0000, 1'b1, ST_DONE, 1'b1, 8'd0, 16'h0000, 5'd2);
        add_row(REQ_INSERT, 8'd7,   16'h0000, 1'b0, ST_DONE, 1'b0, 8'd0, 16'h0000, 5'd0);
        add_row(REQ_INSERT, 8'd0,   16'h0000, 1'b0, ST_DONE, 1'b0, 8'd0, 16'h0000, 5'd0);
        add_row(REQ_REMOVE, 8'd0,   16'hFFFF, 1'b0, ST_DONE, 1'b0, 8'd0, 16'h0000, 5'd0);
        add_row(REQ_REMOVE, 8'd200, 16'h0000, 1'b1, ST_NOT_FOUND, 1'b1, 8'd0, 16'h0000, 5'd3);
        // fill up to the last slot
        for (int i = 0; i < DEPTH - 3; i++) begin
            add_row(REQ_INSERT, 8'(16 + i), 16'(i * 16'h1357), 1'b0,
                    ST_DONE, 1'b0, 8'd0, 16'h0000, 5'd0);
        end
        // full queue refuses, then remove the tail entry and one near the head
        add_row(REQ_INSERT, 8'd99,  16'h0001, 1'b1, ST_FULL, 1'b1, 8'd0, 16'h0000, 5'd16);
        add_row(REQ_REMOVE, 8'd255, 16'h0000, 1'b0, ST_DONE, 1'b0, 8'd0, 16'h0000, 5'd0);
        add_row(REQ_REMOVE, 8'd7,   16'h0000, 1'b0, ST_DONE, 1'b0, 8'd0, 16'h0000, 5'd0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].kind, directed_rows[i].req,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // random traffic, leaning toward filling or draining in turns
        fill_bias = 75;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) begin
                backlog_req <= 1'b1;
            end
            quiet <= (n >= 300 && n < 450);
            if (n % 40 == 0) begin
                fill_bias = $urandom_range(1) ? 75 : 25;
            end
            kind = ($urandom_range(99) < fill_bias) ? REQ_INSERT : REQ_REMOVE;
            case ($urandom_range(3))
                0:       e.stamp = 16'($urandom_range(7));
                1:       e.stamp = 16'hFFFF - 16'($urandom_range(3));
                default: e.stamp = 16'($urandom);
            endcase
            if (kind == REQ_REMOVE && slot_count > 0 && $urandom_range(9) < 8) begin
                e.proc_id = sorted_slots[$urandom_range(slot_count - 1)].proc_id;
            end else if ($urandom_range(1) == 1) begin
                e.proc_id = 8'($urandom_range(15));
            end else begin
                e.proc_id = 8'($urandom);
            end
            offer_request(kind, e, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain, then a short settle for stray results
        while (head_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
